FILE: src/scpq_pkg.sv
// scpq_pkg: shared types and constants of the stable class priority queue
// no dependencies; imported by scpq_store, scpq_ctrl and the top level
`default_nettype none
package scpq_pkg;

	localparam int ID_W  = 16;
	localparam int CLS_W = 3;
	localparam int ST_W  = 3;

	// command codes
	localparam logic CMD_ENQ = 1'b0;
	localparam logic CMD_DEQ = 1'b1;

	// status codes
	localparam logic [ST_W-1:0] ST_OK        = 3'd0;
	localparam logic [ST_W-1:0] ST_EMPTY     = 3'd1;
	localparam logic [ST_W-1:0] ST_FULL      = 3'd2;
	localparam logic [ST_W-1:0] ST_BAD_CLASS = 3'd3;
	localparam logic [ST_W-1:0] ST_BAD_ID    = 3'd4;

	// register map
	localparam logic REG_ID_LIMIT = 1'b0;
	localparam logic [ID_W-1:0] ID_LIMIT_RESET = 16'd50000;

	typedef enum logic {
		S_IDLE,
		S_EXEC
	} state_t;

	typedef struct packed {
		logic [ST_W-1:0]  status;
		logic             popped_valid;
		logic [CLS_W-1:0] popped_class;
		logic [ID_W-1:0]  popped_identifier;
	} result_t;

endpackage
`default_nettype wire

FILE: src/scpq_store.sv
// scpq_store: entry memories, link and identifier, registered read
// uses scpq_pkg for the identifier width
`default_nettype none
module scpq_store #(
	parameter int DEPTH = 256,
	parameter int AW    = 8
) (
	input  wire logic                      clk,
	input  wire logic                      rd_en,
	input  wire logic [AW-1:0]             rd_addr,
	output logic [AW-1:0]                  link_rdata,
	output logic [scpq_pkg::ID_W-1:0]      id_rdata,
	input  wire logic                      link_we,
	input  wire logic [AW-1:0]             link_waddr,
	input  wire logic [AW-1:0]             link_wdata,
	input  wire logic                      id_we,
	input  wire logic [AW-1:0]             id_waddr,
	input  wire logic [scpq_pkg::ID_W-1:0] id_wdata
);
	import scpq_pkg::*;

	logic [AW-1:0]   link_mem [DEPTH];
	logic [ID_W-1:0] id_mem   [DEPTH];

	always_ff @(posedge clk) begin
		if (link_we) begin
			link_mem[link_waddr] <= link_wdata;
		end
		if (rd_en) begin
			link_rdata <= link_mem[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (id_we) begin
			id_mem[id_waddr] <= id_wdata;
		end
		if (rd_en) begin
			id_rdata <= id_mem[rd_addr];
		end
	end

endmodule
`default_nettype wire

FILE: src/scpq_ctrl.sv
// scpq_ctrl: command sequencer, class pointers, free list and fill count
// uses scpq_pkg; drives the memory ports of scpq_store
`default_nettype none
module scpq_ctrl #(
	parameter int CAPACITY = 256,
	parameter int CLASSES  = 4,
	parameter int AW       = 8,
	parameter int CW       = 9,
	parameter int CIW      = 2
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       in_valid,
	output logic                            in_stall,
	input  wire logic                       command,
	input  wire logic [scpq_pkg::CLS_W-1:0] class_number,
	input  wire logic [scpq_pkg::ID_W-1:0]  identifier,
	input  wire logic [scpq_pkg::ID_W-1:0]  id_limit,
	input  wire logic                       out_free,
	output logic                            done,
	output scpq_pkg::result_t               result,
	output logic [CW-1:0]                   occ,
	output logic                            rd_en,
	output logic [AW-1:0]                   rd_addr,
	input  wire logic [AW-1:0]              link_rdata,
	input  wire logic [scpq_pkg::ID_W-1:0]  id_rdata,
	output logic                            link_we,
	output logic [AW-1:0]                   link_waddr,
	output logic [AW-1:0]                   link_wdata,
	output logic                            id_we,
	output logic [AW-1:0]                   id_waddr,
	output logic [scpq_pkg::ID_W-1:0]       id_wdata
);
	import scpq_pkg::*;

	state_t state_q, state_d;

	// command register
	logic            op_q;
	logic            ok_q;
	logic [ST_W-1:0] stat_q;
	logic [CIW-1:0]  c_q;
	logic [ID_W-1:0] id_q;
	logic [AW-1:0]   node_q;

	// queue state
	logic [AW-1:0] free_head_q;
	logic [CW-1:0] hwm_q;
	logic [CW-1:0] total_q;
	logic [AW-1:0] head_q  [CLASSES];
	logic [AW-1:0] tail_q  [CLASSES];
	logic [CW-1:0] count_q [CLASSES];

	logic            accept;
	logic            cls_ok, id_ok, full, any_busy;
	logic [CIW-1:0]  cls_idx, deq_c, acc_c;
	logic [ST_W-1:0] acc_stat;
	logic [CW-1:0]   cnt_c;
	logic            last;
	logic            fresh;
	logic [AW-1:0]   fresh_next, enq_next_fh;
	logic            commit;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: if (in_valid) state_d = S_EXEC;
			S_EXEC: if (out_free) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		in_stall = 1'b1;
		done     = 1'b0;
		unique case (state_q)
			S_IDLE: in_stall = 1'b0;
			S_EXEC: done = out_free;
			default: in_stall = 1'b1;
		endcase
	end

	assign accept = in_valid && !in_stall;
	assign commit = done && ok_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// operand checks and front-class search
	assign cls_ok  = (class_number != '0) && (32'(class_number) <= CLASSES);
	assign cls_idx = CIW'(class_number - CLS_W'(1));
	assign id_ok   = (identifier != '0) && (identifier <= id_limit);
	assign full    = (32'(total_q) >= CAPACITY);

	always_comb begin
		deq_c    = '0;
		any_busy = 1'b0;
		for (int i = CLASSES - 1; i >= 0; i--) begin
			if (count_q[i] != '0) begin
				deq_c    = CIW'(i);
				any_busy = 1'b1;
			end
		end
	end

	always_comb begin
		if (command == CMD_DEQ) begin
			acc_stat = any_busy ? ST_OK : ST_EMPTY;
			acc_c    = deq_c;
			rd_addr  = head_q[deq_c];
		end else begin
			acc_c    = cls_idx;
			rd_addr  = free_head_q;
			if (!cls_ok)     acc_stat = ST_BAD_CLASS;
			else if (!id_ok) acc_stat = ST_BAD_ID;
			else if (full)   acc_stat = ST_FULL;
			else             acc_stat = ST_OK;
		end
	end

	assign rd_en = accept;

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q   <= command;
			ok_q   <= (acc_stat == ST_OK);
			stat_q <= acc_stat;
			c_q    <= acc_c;
			id_q   <= identifier;
			node_q <= rd_addr;
		end
	end

	// entries at or above the fill count were never written; their free chain link is the next index
	assign fresh       = (CW'(node_q) == hwm_q);
	assign fresh_next  = (32'(node_q) == CAPACITY - 1) ? '0 : node_q + AW'(1);
	assign enq_next_fh = fresh ? fresh_next : link_rdata;
	assign cnt_c       = count_q[c_q];
	assign last        = (cnt_c == CW'(1));

	// at most one link write per command: tail append on enqueue to a non-empty class, free push on dequeue
	always_comb begin
		link_we    = commit && ((op_q == CMD_DEQ) || (cnt_c != '0));
		link_waddr = (op_q == CMD_DEQ) ? node_q : tail_q[c_q];
		link_wdata = (op_q == CMD_DEQ) ? free_head_q : node_q;
		id_we      = commit && (op_q == CMD_ENQ);
		id_waddr   = node_q;
		id_wdata   = id_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			free_head_q <= '0;
			hwm_q       <= '0;
			total_q     <= '0;
			for (int i = 0; i < CLASSES; i++) begin
				head_q[i]  <= '0;
				tail_q[i]  <= '0;
				count_q[i] <= '0;
			end
		end else if (commit) begin
			if (op_q == CMD_ENQ) begin
				free_head_q <= enq_next_fh;
				if (fresh) hwm_q <= hwm_q + CW'(1);
				if (cnt_c == '0) head_q[c_q] <= node_q;
				tail_q[c_q]  <= node_q;
				count_q[c_q] <= cnt_c + CW'(1);
				total_q      <= total_q + CW'(1);
			end else begin
				head_q[c_q] <= last ? '0 : link_rdata;
				if (last) tail_q[c_q] <= '0;
				count_q[c_q] <= cnt_c - CW'(1);
				free_head_q  <= node_q;
				total_q      <= total_q - CW'(1);
			end
		end
	end

	// result word
	always_comb begin
		result.status            = stat_q;
		result.popped_valid      = ok_q && (op_q == CMD_DEQ);
		result.popped_class      = result.popped_valid ? CLS_W'(c_q) + CLS_W'(1) : '0;
		result.popped_identifier = result.popped_valid ? id_rdata : '0;
		if (!ok_q)                 occ = total_q;
		else if (op_q == CMD_DEQ)  occ = total_q - CW'(1);
		else                       occ = total_q + CW'(1);
	end

endmodule
`default_nettype wire

FILE: src/stable_class_priority_queue.sv
// stable_class_priority_queue: enqueue/dequeue queue ordered by class, fifo within a class
// a word is accepted only in idle; its result is registered once the output slot is free
// a new word is taken only after the last is done, set by the read-modify-write of the entry memories
// reset: pointers and counts clear at once; no clearing pass, a fill count stands in for
// the reset free chain; identifier limit resets to 50000
`default_nettype none
module stable_class_priority_queue #(
	parameter int CAPACITY = 256,
	parameter int CLASSES  = 4,
	localparam int AW      = $clog2(CAPACITY),
	localparam int CW      = $clog2(CAPACITY + 1)
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	// command channel
	input  wire logic                       in_valid,
	output logic                            in_stall,
	input  wire logic                       command,
	input  wire logic [scpq_pkg::CLS_W-1:0] class_number,
	input  wire logic [scpq_pkg::ID_W-1:0]  identifier,
	// result channel
	output logic                            out_valid,
	input  wire logic                       out_stall,
	output logic [scpq_pkg::ST_W-1:0]       status,
	output logic                            popped_valid,
	output logic [scpq_pkg::CLS_W-1:0]      popped_class,
	output logic [scpq_pkg::ID_W-1:0]       popped_identifier,
	output logic [CW-1:0]                   occupancy,
	// configuration port
	input  wire logic                       psel,
	input  wire logic                       penable,
	input  wire logic                       pwrite,
	input  wire logic [2:0]                 paddr,
	input  wire logic [31:0]                pwdata,
	output logic [31:0]                     prdata,
	output logic                            pready
);
	import scpq_pkg::*;

	localparam int CIW = $clog2(CLASSES);

	logic [ID_W-1:0] id_limit_q;

	// store <-> sequencer
	logic            rd_en;
	logic [AW-1:0]   rd_addr;
	logic [AW-1:0]   link_rdata;
	logic [ID_W-1:0] id_rdata;
	logic            link_we;
	logic [AW-1:0]   link_waddr, link_wdata;
	logic            id_we;
	logic [AW-1:0]   id_waddr;
	logic [ID_W-1:0] id_wdata;

	logic          done;
	result_t       result;
	logic [CW-1:0] occ;
	logic          out_free;

	// output register
	logic          out_valid_q;
	result_t       res_q;
	logic [CW-1:0] occ_q;

	// register write on the access phase; paddr[2] picks the register slot
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			id_limit_q <= ID_LIMIT_RESET;
		end else if (psel && penable && pwrite && pready && (paddr[2] == REG_ID_LIMIT)) begin
			id_limit_q <= pwdata[ID_W-1:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (paddr[2] == REG_ID_LIMIT) prdata = {{(32 - ID_W){1'b0}}, id_limit_q};
	end

	scpq_store #(
		.DEPTH (CAPACITY),
		.AW    (AW)
	) u_store (
		.clk        (clk),
		.rd_en      (rd_en),
		.rd_addr    (rd_addr),
		.link_rdata (link_rdata),
		.id_rdata   (id_rdata),
		.link_we    (link_we),
		.link_waddr (link_waddr),
		.link_wdata (link_wdata),
		.id_we      (id_we),
		.id_waddr   (id_waddr),
		.id_wdata   (id_wdata)
	);

	scpq_ctrl #(
		.CAPACITY (CAPACITY),
		.CLASSES  (CLASSES),
		.AW       (AW),
		.CW       (CW),
		.CIW      (CIW)
	) u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.command      (command),
		.class_number (class_number),
		.identifier   (identifier),
		.id_limit     (id_limit_q),
		.out_free     (out_free),
		.done         (done),
		.result       (result),
		.occ          (occ),
		.rd_en        (rd_en),
		.rd_addr      (rd_addr),
		.link_rdata   (link_rdata),
		.id_rdata     (id_rdata),
		.link_we      (link_we),
		.link_waddr   (link_waddr),
		.link_wdata   (link_wdata),
		.id_we        (id_we),
		.id_waddr     (id_waddr),
		.id_wdata     (id_wdata)
	);

	// the output slot frees when empty or when its word is taken this cycle;
	// the sequencer holds a finished command until then
	assign out_free = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (done) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (done) begin
			res_q <= result;
			occ_q <= occ;
		end
	end

	assign out_valid         = out_valid_q;
	assign status            = res_q.status;
	assign popped_valid      = res_q.popped_valid;
	assign popped_class      = res_q.popped_class;
	assign popped_identifier = res_q.popped_identifier;
	assign occupancy         = occ_q;

	// the sequencer never accepts commands back to back
	a_two_cycle: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall)
		else $error("command accepted in back-to-back cycles");

	// occupancy never passes capacity
	a_occ_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (32'(occupancy) <= CAPACITY))
		else $error("occupancy above capacity");

	// a returned entry always comes with ok status and a real class
	a_pop_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && popped_valid) |-> (status == ST_OK && popped_class != '0))
		else $error("popped entry with bad status or class");

	// a finished word never overwrites one still waiting
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> (out_valid && $stable(status) && $stable(occupancy)))
		else $error("waiting result word lost");

endmodule
`default_nettype wire
